[rtl/jsu_pkg.sv]
// Shared types, decode phase codes, status codes and character constants
// for the JSON string unescaper. No dependencies.
package jsu_pkg;

  // Decode phase codes
  localparam logic [2:0] PH_NORMAL = 3'd0;
  localparam logic [2:0] PH_ESCAPE = 3'd1;
  localparam logic [2:0] PH_HEX1   = 3'd2;
  localparam logic [2:0] PH_HEX2   = 3'd3;
  localparam logic [2:0] PH_HEX3   = 3'd4;
  localparam logic [2:0] PH_HEX4   = 3'd5;
  localparam logic [2:0] PH_DROP   = 3'd6;

  // Result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_UNKNOWN = 3'd1;
  localparam logic [2:0] ST_TRUNC   = 3'd2;
  localparam logic [2:0] ST_BADHEX  = 3'd3;
  localparam logic [2:0] ST_TOOBIG  = 3'd4;

  // Characters of interest
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_BSL   = 8'h5C;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_U     = 8'h75;

  // Control bytes produced by escapes
  localparam logic [7:0] CTL_BS = 8'h08;
  localparam logic [7:0] CTL_FF = 8'h0C;
  localparam logic [7:0] CTL_LF = 8'h0A;
  localparam logic [7:0] CTL_CR = 8'h0D;
  localparam logic [7:0] CTL_HT = 8'h09;

  // Decoder state: phase, low byte of the hex value, and a flag set once
  // any digit has been shifted beyond the low byte with a non-zero value
  typedef struct packed {
    logic [2:0] phase;
    logic [7:0] acc;
    logic       big;
  } jsu_state_t;

  // One step of the decoder: next state and an optional result
  typedef struct packed {
    jsu_state_t nxt;
    logic       emit;
    logic [7:0] byte_val;
    logic [2:0] status;
    logic       last;
  } jsu_step_t;

  // Hex digit lookup: bit 4 flags a valid digit, bits 3:0 hold its value
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

[rtl/json_string_unescaper.sv]
// Top level of the JSON string unescaper: phase registers, result register
// and stream handshakes. Depends on jsu_pkg and jsu_decode.
//
// Usage:
//   Raw bytes of a JSON string body enter on the in_ channel, one per
//   transfer, with in_tlast on the final byte. Decoded bytes leave on the
//   out_ channel: out_tdata carries the byte, out_tuser the status, and
//   out_tlast closes the string. An error gives one result with zero data,
//   a non-zero status and out_tlast set; input bytes up to the next
//   in_tlast are then dropped.
//   A result is registered and appears in the cycle after the transfer
//   of the byte that completes it. Backslash, 'u' and the first three hex
//   digits of a well-formed escape give no result.
//   Throughput: one byte per cycle. The single result register is
//   refilled in the cycle it is emptied, so in_tready stays high while
//   the receiver takes each result.
//   Stall: while a result waits with out_tready low, in_tready is low.
//   Reset (rst_n low, synchronous): the phase returns to normal and the
//   result register is emptied.
module json_string_unescaper (
  input  logic       clk,
  input  logic       rst_n,
  // Input channel
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  // Result channel
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [2:0] out_tuser,  // [2:0] status
  output logic       out_tlast
);

  jsu_pkg::jsu_state_t state_r;
  jsu_pkg::jsu_step_t  step;
  logic                in_xfer;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic [7:0]          out_byte_r;
  logic [2:0]          out_status_r;
  logic                out_last_r;

  jsu_decode u_decode (
    .cur     (state_r),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .step    (step)
  );

  // Accept while the result register is empty or being emptied
  assign in_tready = !out_valid_r || out_tready;
  assign in_xfer   = in_tvalid && in_tready;

  // Advance the decode phase on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.phase <= jsu_pkg::PH_NORMAL;
      state_r.acc   <= 8'd0;
      state_r.big   <= 1'b0;
    end else if (in_xfer) begin
      state_r <= step.nxt;
    end
  end

  // Hold a result until the receiver takes it
  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    if (in_xfer && step.emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (in_xfer && step.emit) begin
      out_byte_r   <= step.byte_val;
      out_status_r <= step.status;
      out_last_r   <= step.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

[rtl/jsu_decode.sv]
// Combinational next-state and result logic for one raw byte.
// Depends on jsu_pkg.
module jsu_decode (
  input  jsu_pkg::jsu_state_t cur,
  input  logic [7:0]          in_byte,
  input  logic                in_last,
  output jsu_pkg::jsu_step_t  step
);

  logic [4:0] hd;
  logic [7:0] acc_sh;
  logic       big_sh;

  assign hd     = jsu_pkg::hex_digit(in_byte);
  assign acc_sh = {cur.acc[3:0], hd[3:0]};
  assign big_sh = cur.big | (cur.acc[7:4] != 4'd0);

  // Work out the next phase and any result for this byte
  always_comb begin
    step          = '0;
    step.nxt      = cur;
    step.emit     = 1'b0;
    step.byte_val = 8'd0;
    step.status   = jsu_pkg::ST_OK;
    step.last     = in_last;

    unique case (cur.phase)
      jsu_pkg::PH_DROP: begin
        if (in_last) begin
          step.nxt.phase = jsu_pkg::PH_NORMAL;
        end
      end

      jsu_pkg::PH_ESCAPE: begin
        step.nxt.phase = jsu_pkg::PH_NORMAL;
        step.emit      = 1'b1;
        case (in_byte)
          jsu_pkg::CH_QUOTE: step.byte_val = jsu_pkg::CH_QUOTE;
          jsu_pkg::CH_BSL:   step.byte_val = jsu_pkg::CH_BSL;
          jsu_pkg::CH_SLASH: step.byte_val = jsu_pkg::CH_SLASH;
          jsu_pkg::CH_B:     step.byte_val = jsu_pkg::CTL_BS;
          jsu_pkg::CH_F:     step.byte_val = jsu_pkg::CTL_FF;
          jsu_pkg::CH_N:     step.byte_val = jsu_pkg::CTL_LF;
          jsu_pkg::CH_R:     step.byte_val = jsu_pkg::CTL_CR;
          jsu_pkg::CH_T:     step.byte_val = jsu_pkg::CTL_HT;
          jsu_pkg::CH_U: begin
            if (in_last) begin
              step.status = jsu_pkg::ST_TRUNC;
              step.last   = 1'b1;
            end else begin
              step.emit      = 1'b0;
              step.nxt.phase = jsu_pkg::PH_HEX1;
              step.nxt.acc   = 8'd0;
              step.nxt.big   = 1'b0;
            end
          end
          default: begin
            step.status = jsu_pkg::ST_UNKNOWN;
            step.last   = 1'b1;
            if (!in_last) begin
              step.nxt.phase = jsu_pkg::PH_DROP;
            end
          end
        endcase
      end

      jsu_pkg::PH_HEX1, jsu_pkg::PH_HEX2, jsu_pkg::PH_HEX3, jsu_pkg::PH_HEX4: begin
        if (cur.phase != jsu_pkg::PH_HEX4 && in_last) begin
          step.emit      = 1'b1;
          step.status    = jsu_pkg::ST_TRUNC;
          step.nxt.phase = jsu_pkg::PH_NORMAL;
        end else if (!hd[4]) begin
          step.emit      = 1'b1;
          step.status    = jsu_pkg::ST_BADHEX;
          step.last      = 1'b1;
          step.nxt.phase = in_last ? jsu_pkg::PH_NORMAL : jsu_pkg::PH_DROP;
        end else if (cur.phase != jsu_pkg::PH_HEX4) begin
          step.nxt.phase = cur.phase + 3'd1;
          step.nxt.acc   = acc_sh;
          step.nxt.big   = big_sh;
        end else if (big_sh) begin
          step.emit      = 1'b1;
          step.status    = jsu_pkg::ST_TOOBIG;
          step.last      = 1'b1;
          step.nxt.phase = in_last ? jsu_pkg::PH_NORMAL : jsu_pkg::PH_DROP;
        end else begin
          step.emit      = 1'b1;
          step.byte_val  = acc_sh;
          step.nxt.phase = jsu_pkg::PH_NORMAL;
        end
        // Any result from a hex digit closes the escape: clear the gather
        if (step.emit) begin
          step.nxt.acc = 8'd0;
          step.nxt.big = 1'b0;
        end
      end

      default: begin
        step.nxt.phase = jsu_pkg::PH_NORMAL;
        if (in_byte == jsu_pkg::CH_BSL) begin
          if (in_last) begin
            step.emit   = 1'b1;
            step.status = jsu_pkg::ST_TRUNC;
          end else begin
            step.nxt.phase = jsu_pkg::PH_ESCAPE;
          end
        end else begin
          step.emit     = 1'b1;
          step.byte_val = in_byte;
        end
      end
    endcase
  end

endmodule

[rtl/jsu_checker.sv]
// Port-level checks on the JSON string unescaper, bound to the top level.
// Depends on jsu_pkg and json_string_unescaper.
module jsu_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic [2:0] out_tuser,
  input logic       out_tlast
);

  // An error result closes the string
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != jsu_pkg::ST_OK |-> out_tlast)
    else $error("error result without tlast");

  // An error result carries zero data
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != jsu_pkg::ST_OK |-> out_tdata == 8'd0)
    else $error("error result with non-zero data");

  // Status is one of the defined codes
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= jsu_pkg::ST_TOOBIG)
    else $error("status out of range");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind json_string_unescaper jsu_checker u_jsu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
